// ===== hdl/bste_pkg.sv =====
// ----------------------------------------------------------------------------
// bste_pkg
// Shared types and codes for the banked stack table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bste_pkg;

  localparam int unsigned CNT_W  = 5;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [2:0] {
    CMD_CREATE   = 3'd0,
    CMD_PUSH     = 3'd1,
    CMD_POP      = 3'd2,
    CMD_DELETE   = 3'd3,
    CMD_RESIZE   = 3'd4,
    CMD_COUNT    = 3'd5,
    CMD_READ     = 3'd6,
    CMD_READ_SRT = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_BAD_BANK     = 4'd1,
    ST_BAD_SIZE     = 4'd2,
    ST_EXISTS       = 4'd3,
    ST_NO_BANK      = 4'd4,
    ST_FULL         = 4'd5,
    ST_EMPTY        = 4'd6,
    ST_NOT_FOUND    = 4'd7,
    ST_BAD_NEW_SIZE = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_DEL_RD,
    S_DEL_CHK,
    S_DEL_SH_RD,
    S_DEL_SH_WR,
    S_CP_RD,
    S_CP_WR,
    S_SRT_KEY_RD,
    S_SRT_KEY,
    S_SRT_CMP_RD,
    S_SRT_CMP,
    S_SRT_INS,
    S_OUT_RD,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/bste_ram.sv =====
// ----------------------------------------------------------------------------
// bste_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bste_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/banked_stack_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// banked_stack_table_engine_core
// Banked bounded stacks of signed words with delete, resize and sorted read.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in an item; results appear on
// status/count/data/last for one cycle each, marked by valid, and cannot be
// held off. Simple commands answer from the decode state, with registered
// results. Delete walks the bank through the single element RAM, reading
// each entry searched and reading then writing each entry shifted. Read
// copies the bank entry by entry into a scratch RAM, then emits its results
// with a scratch read before each; read sorted first adds an insertion sort
// on the single scratch RAM, with a read before each compare/shift.
`default_nettype none

module banked_stack_table_engine_core #(
  parameter int unsigned NUM_BANKS = 8,
  parameter int unsigned MAX_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          cmd,
  input  wire logic [3:0]          bank,
  input  wire logic signed [31:0]  value,
  input  wire logic signed [5:0]   size_delta,
  output logic                     valid,
  output logic [3:0]               status,
  output logic [4:0]               count,
  output logic signed [31:0]       data,
  output logic                     last
);

  localparam int unsigned BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int unsigned IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned ED = NUM_BANKS * MAX_DEPTH;
  localparam int unsigned AW = (ED > 1) ? $clog2(ED) : 1;
  localparam int unsigned CW = bste_pkg::CNT_W;

  bste_pkg::state_t state, state_next;

  logic [2:0]          cmd_q;
  logic [3:0]          bank_q;
  logic signed [31:0]  value_q;
  logic signed [5:0]   delta_q;

  logic                bank_exists   [NUM_BANKS];
  logic [CW-1:0]       bank_capacity [NUM_BANKS];
  logic [CW-1:0]       bank_fill     [NUM_BANKS];

  logic [CW-1:0] i, i_next, j, j_next, n, n_next;
  logic signed [31:0] key, key_next;

  logic          meta_we, exists_next;
  logic [CW-1:0] cap_next, fill_next;

  logic          valid_next, last_next;
  logic [3:0]    status_next;
  logic [4:0]    count_next;
  logic [31:0]   data_next;

  logic          e_we, s_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [IW-1:0] s_waddr, s_raddr;
  logic [31:0]   e_wdata, e_rdata, s_wdata, s_rdata;

  logic [BW-1:0]      bi;
  logic               bank_bad;
  logic               cur_exists;
  logic [CW-1:0]      cur_cap, cur_fill;
  logic [CW-1:0]      ip1, ip2, jm1;
  logic [AW-1:0]      row_base;
  logic signed [6:0]  newcap;

  assign bi         = bank_q[BW-1:0];
  assign bank_bad   = ({1'b0, bank_q} >= 5'(NUM_BANKS));
  assign cur_exists = bank_exists[bi];
  assign cur_cap    = bank_capacity[bi];
  assign cur_fill   = bank_fill[bi];
  assign ip1        = i + CW'(1);
  assign ip2        = i + CW'(2);
  assign jm1        = j - CW'(1);
  assign row_base   = AW'(bi) * AW'(MAX_DEPTH);
  assign newcap     = $signed({2'b00, cur_cap}) + $signed({delta_q[5], delta_q});
  assign busy       = (state != bste_pkg::S_IDLE);

  bste_ram #(.WIDTH(32), .DEPTH(ED)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  bste_ram #(.WIDTH(32), .DEPTH(MAX_DEPTH)) u_scratch (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bste_pkg::S_IDLE: begin
        if (start) state_next = bste_pkg::S_DEC;
      end
      bste_pkg::S_DEC: begin
        state_next = bste_pkg::S_IDLE;
        if (!bank_bad && cur_exists && cur_fill != '0) begin
          if (cmd_q == bste_pkg::CMD_DELETE) state_next = bste_pkg::S_DEL_RD;
          if (cmd_q == bste_pkg::CMD_READ || cmd_q == bste_pkg::CMD_READ_SRT)
            state_next = bste_pkg::S_CP_RD;
        end
      end
      bste_pkg::S_DEL_RD: state_next = bste_pkg::S_DEL_CHK;
      bste_pkg::S_DEL_CHK: begin
        if ($signed(e_rdata) == value_q) begin
          state_next = (ip1 < cur_fill) ? bste_pkg::S_DEL_SH_RD : bste_pkg::S_IDLE;
        end else begin
          state_next = (ip1 == cur_fill) ? bste_pkg::S_IDLE : bste_pkg::S_DEL_RD;
        end
      end
      bste_pkg::S_DEL_SH_RD: state_next = bste_pkg::S_DEL_SH_WR;
      bste_pkg::S_DEL_SH_WR: begin
        state_next = (ip2 < cur_fill) ? bste_pkg::S_DEL_SH_RD : bste_pkg::S_IDLE;
      end
      bste_pkg::S_CP_RD: state_next = bste_pkg::S_CP_WR;
      bste_pkg::S_CP_WR: begin
        if (ip1 < n) state_next = bste_pkg::S_CP_RD;
        else if (cmd_q == bste_pkg::CMD_READ_SRT && n > CW'(1))
          state_next = bste_pkg::S_SRT_KEY_RD;
        else state_next = bste_pkg::S_OUT_RD;
      end
      bste_pkg::S_SRT_KEY_RD: state_next = bste_pkg::S_SRT_KEY;
      bste_pkg::S_SRT_KEY:    state_next = bste_pkg::S_SRT_CMP_RD;
      bste_pkg::S_SRT_CMP_RD: state_next = bste_pkg::S_SRT_CMP;
      bste_pkg::S_SRT_CMP: begin
        if (key < $signed(s_rdata)) begin
          state_next = (jm1 != '0) ? bste_pkg::S_SRT_CMP_RD : bste_pkg::S_SRT_INS;
        end else begin
          state_next = (ip1 < n) ? bste_pkg::S_SRT_KEY_RD : bste_pkg::S_OUT_RD;
        end
      end
      bste_pkg::S_SRT_INS: begin
        state_next = (ip1 < n) ? bste_pkg::S_SRT_KEY_RD : bste_pkg::S_OUT_RD;
      end
      bste_pkg::S_OUT_RD: state_next = bste_pkg::S_OUT;
      bste_pkg::S_OUT: begin
        state_next = (ip1 == n) ? bste_pkg::S_IDLE : bste_pkg::S_OUT_RD;
      end
      default: state_next = bste_pkg::S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    i_next      = i;
    j_next      = j;
    n_next      = n;
    key_next    = key;
    meta_we     = 1'b0;
    exists_next = cur_exists;
    cap_next    = cur_cap;
    fill_next   = cur_fill;
    e_we        = 1'b0;
    e_waddr     = row_base + AW'(i[IW-1:0]);
    e_wdata     = value_q;
    e_raddr     = row_base + AW'(i[IW-1:0]);
    s_we        = 1'b0;
    s_waddr     = i[IW-1:0];
    s_wdata     = e_rdata;
    s_raddr     = i[IW-1:0];
    valid_next  = 1'b0;
    last_next   = 1'b1;
    status_next = bste_pkg::ST_OK;
    count_next  = cur_fill;
    data_next   = '0;

    case (state)
      bste_pkg::S_DEC: begin
        i_next = '0;
        n_next = (cur_fill > CW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : cur_fill;
        valid_next = 1'b1;
        if (bank_bad) begin
          status_next = bste_pkg::ST_BAD_BANK;
          count_next  = '0;
        end else if (cmd_q == bste_pkg::CMD_CREATE) begin
          if (delta_q < 6'sd1 || delta_q > $signed(6'(MAX_DEPTH))) begin
            status_next = bste_pkg::ST_BAD_SIZE;
          end else if (cur_exists) begin
            status_next = bste_pkg::ST_EXISTS;
          end else begin
            meta_we     = 1'b1;
            exists_next = 1'b1;
            cap_next    = CW'(delta_q);
            fill_next   = '0;
            count_next  = '0;
          end
        end else if (!cur_exists) begin
          status_next = bste_pkg::ST_NO_BANK;
        end else begin
          case (cmd_q)
            bste_pkg::CMD_PUSH: begin
              if (cur_fill >= cur_cap || cur_fill >= CW'(MAX_DEPTH)) begin
                status_next = bste_pkg::ST_FULL;
              end else begin
                e_we       = 1'b1;
                e_waddr    = row_base + AW'(cur_fill[IW-1:0]);
                meta_we    = 1'b1;
                fill_next  = cur_fill + CW'(1);
                count_next = cur_fill + CW'(1);
              end
            end
            bste_pkg::CMD_POP: begin
              if (cur_fill == '0) begin
                status_next = bste_pkg::ST_EMPTY;
              end else begin
                meta_we    = 1'b1;
                fill_next  = cur_fill - CW'(1);
                count_next = cur_fill - CW'(1);
              end
            end
            bste_pkg::CMD_DELETE: begin
              if (cur_fill == '0) status_next = bste_pkg::ST_EMPTY;
              else valid_next = 1'b0;
            end
            bste_pkg::CMD_RESIZE: begin
              if (newcap < 7'sd1 || newcap > $signed(7'(MAX_DEPTH))) begin
                status_next = bste_pkg::ST_BAD_NEW_SIZE;
              end else begin
                meta_we  = 1'b1;
                cap_next = CW'(newcap);
                if (cur_fill > CW'(newcap)) begin
                  fill_next  = CW'(newcap);
                  count_next = CW'(newcap);
                end
              end
            end
            bste_pkg::CMD_COUNT: begin
              if (cur_fill == '0) status_next = bste_pkg::ST_EMPTY;
            end
            default: begin
              if (cur_fill != '0) valid_next = 1'b0;
            end
          endcase
        end
      end
      bste_pkg::S_DEL_CHK: begin
        if ($signed(e_rdata) == value_q) begin
          if (!(ip1 < cur_fill)) begin
            valid_next = 1'b1;
            meta_we    = 1'b1;
            fill_next  = cur_fill - CW'(1);
            count_next = cur_fill - CW'(1);
          end
        end else begin
          i_next = ip1;
          if (ip1 == cur_fill) begin
            valid_next  = 1'b1;
            status_next = bste_pkg::ST_NOT_FOUND;
          end
        end
      end
      bste_pkg::S_DEL_SH_RD: begin
        e_raddr = row_base + AW'(ip1[IW-1:0]);
      end
      bste_pkg::S_DEL_SH_WR: begin
        e_we    = 1'b1;
        e_wdata = e_rdata;
        i_next  = ip1;
        if (!(ip2 < cur_fill)) begin
          valid_next = 1'b1;
          meta_we    = 1'b1;
          fill_next  = cur_fill - CW'(1);
          count_next = cur_fill - CW'(1);
        end
      end
      bste_pkg::S_CP_WR: begin
        s_we   = 1'b1;
        i_next = ip1;
        if (!(ip1 < n)) begin
          i_next = (cmd_q == bste_pkg::CMD_READ_SRT && n > CW'(1)) ? CW'(1) : '0;
        end
      end
      bste_pkg::S_SRT_KEY: begin
        key_next = $signed(s_rdata);
        j_next   = i;
      end
      bste_pkg::S_SRT_CMP_RD: begin
        s_raddr = jm1[IW-1:0];
      end
      bste_pkg::S_SRT_CMP: begin
        s_we    = 1'b1;
        s_waddr = j[IW-1:0];
        if (key < $signed(s_rdata)) begin
          s_wdata = s_rdata;
          j_next  = jm1;
        end else begin
          s_wdata = key;
          i_next  = (ip1 < n) ? ip1 : '0;
        end
      end
      bste_pkg::S_SRT_INS: begin
        s_we    = 1'b1;
        s_waddr = j[IW-1:0];
        s_wdata = key;
        i_next  = (ip1 < n) ? ip1 : '0;
      end
      bste_pkg::S_OUT: begin
        valid_next = 1'b1;
        data_next  = s_rdata;
        last_next  = (ip1 == n);
        i_next     = ip1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bste_pkg::S_IDLE;
      valid <= 1'b0;
      for (int k = 0; k < NUM_BANKS; k++) begin
        bank_exists[k]   <= 1'b0;
        bank_capacity[k] <= '0;
        bank_fill[k]     <= '0;
      end
    end else begin
      state <= state_next;
      valid <= valid_next;
      if (meta_we && !bank_bad) begin
        bank_exists[bi]   <= exists_next;
        bank_capacity[bi] <= cap_next;
        bank_fill[bi]     <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bste_pkg::S_IDLE && start) begin
      cmd_q   <= cmd;
      bank_q  <= bank;
      value_q <= value;
      delta_q <= size_delta;
    end
    i      <= i_next;
    j      <= j_next;
    n      <= n_next;
    key    <= key_next;
    status <= status_next;
    count  <= count_next;
    data   <= data_next;
    last   <= last_next;
  end

endmodule

`default_nettype wire
